>>> design/steady_state_gradient_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the steady-state gradient detector
// Concurrent checks on the rising clock edge; they compile away when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef STEADY_STATE_GRADIENT_DETECTOR_ASSERT_SVH
`define STEADY_STATE_GRADIENT_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every edge out of reset
`define SSGD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen at an edge out of reset
`define SSGD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define SSGD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSGD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> design/sgd_pkg.sv
// ----------------------------------------------------------------------------
// sgd_pkg
// Types and constants shared by the steady-state gradient detector files.
// ----------------------------------------------------------------------------
package sgd_pkg;

  // Beat field widths
  localparam int FIELD_W      = 32;
  localparam int PASS_COUNT_W = 2;

  // Largest pass count shown on a result beat
  localparam int PASS_SHOW_MAX = 3;

  // Shared multiplier operand width and wide accumulator width
  localparam int MUL_W = 32;
  localparam int ACC_W = 3 * MUL_W;

  // Fraction bits of the Q16.16 threshold
  localparam int Q_FRAC = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd2;

  // Request type codes
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Top-level sequencer
  typedef enum logic [1:0] {
    SGD_IDLE,
    SGD_EVAL,
    SGD_WAIT,
    SGD_PUSH
  } sgd_state_t;

  // Gradient unit sequencer
  typedef enum logic [2:0] {
    U_IDLE,
    U_RATE,
    U_PLAIN,
    U_LHS,
    U_RLO,
    U_RHI,
    U_ACC,
    U_CMP
  } sgd_unit_state_t;

  // Gradient unit status back to the top level
  typedef struct packed {
    logic done;
    logic passed;
  } sgd_status_t;

  // One result beat
  typedef struct packed {
    logic                    check_done;
    logic                    check_passed;
    logic [PASS_COUNT_W-1:0] pass_count;
    logic                    stop_request;
  } sgd_result_t;

endpackage

>>> design/sgd_in_if.sv
// ----------------------------------------------------------------------------
// sgd_in_if
// Sample channel: valid/ready handshake with one solver sample per beat.
// ----------------------------------------------------------------------------
interface sgd_in_if;
  import sgd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [FIELD_W-1:0]        iteration_index;
  logic signed [FIELD_W-1:0] current_density;
  logic [FIELD_W-1:0]        solved_time;

  modport source (
    output valid, req_type, iteration_index, current_density, solved_time,
    input  ready
  );

  modport sink (
    input  valid, req_type, iteration_index, current_density, solved_time,
    output ready
  );
endinterface

>>> design/sgd_out_if.sv
// ----------------------------------------------------------------------------
// sgd_out_if
// Result channel: valid/ready handshake with one check result per beat.
// ----------------------------------------------------------------------------
interface sgd_out_if;
  import sgd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    check_done;
  logic                    check_passed;
  logic [PASS_COUNT_W-1:0] pass_count;
  logic                    stop_request;

  modport source (
    output valid, check_done, check_passed, pass_count, stop_request,
    input  ready
  );

  modport sink (
    input  valid, check_done, check_passed, pass_count, stop_request,
    output ready
  );
endinterface

>>> design/sgd_gradient_unit.sv
// ----------------------------------------------------------------------------
// sgd_gradient_unit
// Exact gradient test by cross-multiplication on one shared 32x32 multiplier.
// Plain: |dI| * 2^16 < thr * |dt|; normalized: |dI| * t * 2^16 < thr*|dt|*|I|.
// ----------------------------------------------------------------------------
`include "steady_state_gradient_detector_assert.svh"

module sgd_gradient_unit #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       norm_mode,
  input  logic [sgd_pkg::MUL_W-1:0]  threshold,
  input  logic [SAMPLE_WIDTH-1:0]    cur,
  input  logic [SAMPLE_WIDTH-1:0]    saved_cur,
  input  logic [SAMPLE_WIDTH-1:0]    t,
  input  logic [SAMPLE_WIDTH-1:0]    saved_t,
  output sgd_pkg::sgd_status_t       status
);
  import sgd_pkg::*;

  sgd_unit_state_t state_r, state_nxt;

  // Operand magnitudes, formed at start
  logic [SAMPLE_WIDTH:0]   di_w;
  logic [SAMPLE_WIDTH:0]   dt_w;
  logic [SAMPLE_WIDTH-1:0] di_mag_w;
  logic [SAMPLE_WIDTH-1:0] dt_mag_w;
  logic [SAMPLE_WIDTH-1:0] cur_mag_w;
  logic                    ok_w;

  logic [MUL_W-1:0]   di_mag_r;
  logic [MUL_W-1:0]   dt_mag_r;
  logic [MUL_W-1:0]   cur_mag_r;
  logic [MUL_W-1:0]   t_r;
  logic               ok_r;
  logic               norm_r;

  // Shared multiplier and its partial results
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] prod_r;
  logic [2*MUL_W-1:0] rate_r;
  logic [2*MUL_W-1:0] lhs_r;
  logic [ACC_W-1:0]   acc_r;

  // Signed differences and their magnitudes
  assign di_w      = {cur[SAMPLE_WIDTH-1], cur} - {saved_cur[SAMPLE_WIDTH-1], saved_cur};
  assign dt_w      = {1'b0, t} - {1'b0, saved_t};
  assign di_mag_w  = di_w[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(~di_w + 1'b1) : SAMPLE_WIDTH'(di_w);
  assign dt_mag_w  = dt_w[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(~dt_w + 1'b1) : SAMPLE_WIDTH'(dt_w);
  assign cur_mag_w = cur[SAMPLE_WIDTH-1] ? (~cur + 1'b1) : cur;
  // Zero step, or zero current in normalized mode, always fails
  assign ok_w      = (dt_w != '0) && (!norm_mode || (cur != '0));

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      U_IDLE:  if (start) state_nxt = U_RATE;
      U_RATE:  state_nxt = norm_r ? U_LHS : U_PLAIN;
      U_PLAIN: state_nxt = U_CMP;
      U_LHS:   state_nxt = U_RLO;
      U_RLO:   state_nxt = U_RHI;
      U_RHI:   state_nxt = U_ACC;
      U_ACC:   state_nxt = U_CMP;
      U_CMP:   state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  // Multiplier operand select and status
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    status.done   = 1'b0;
    status.passed = 1'b0;
    unique case (state_r)
      U_RATE: begin
        mul_a = threshold;
        mul_b = dt_mag_r;
      end
      U_LHS: begin
        mul_a = di_mag_r;
        mul_b = t_r;
      end
      U_RLO: begin
        mul_a = rate_r[MUL_W-1:0];
        mul_b = cur_mag_r;
      end
      U_RHI: begin
        mul_a = rate_r[2*MUL_W-1:MUL_W];
        mul_b = cur_mag_r;
      end
      U_CMP: begin
        status.done   = 1'b1;
        status.passed = ok_r && (ACC_W'({lhs_r, {Q_FRAC{1'b0}}}) < acc_r);
      end
      default: begin
      end
    endcase
  end

  // Datapath: capture operands, register each product, collect partials
  always_ff @(posedge clk) begin
    prod_r <= (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
    if (state_r == U_IDLE && start) begin
      di_mag_r  <= MUL_W'(di_mag_w);
      dt_mag_r  <= MUL_W'(dt_mag_w);
      cur_mag_r <= MUL_W'(cur_mag_w);
      t_r       <= MUL_W'(t);
      ok_r      <= ok_w;
      norm_r    <= norm_mode;
    end
    case (state_r)
      U_PLAIN: begin
        acc_r <= ACC_W'(prod_r);
        lhs_r <= (2*MUL_W)'(di_mag_r);
      end
      U_LHS: rate_r <= prod_r;
      U_RLO: lhs_r  <= prod_r;
      U_RHI: acc_r  <= ACC_W'(prod_r);
      U_ACC: acc_r  <= acc_r + {prod_r, {MUL_W{1'b0}}};
      default: begin
      end
    endcase
  end

  `SSGD_ASSERT(a_start_when_idle, clk, rst_n, start |-> state_r == U_IDLE, "start while busy")
  `SSGD_ASSERT(a_idle_after_done, clk, rst_n, status.done |=> state_r == U_IDLE, "no idle after compare")
  `SSGD_ASSERT(a_rate_branch, clk, rst_n, state_r == U_RATE |=> (state_r == U_LHS || state_r == U_PLAIN), "bad branch after rate product")

endmodule

>>> design/steady_state_gradient_detector.sv
// ----------------------------------------------------------------------------
// steady_state_gradient_detector
// Watches solver iteration samples and requests a stop once the current
// density gradient has stayed below threshold for enough consecutive checks.
// ----------------------------------------------------------------------------
// Each beat yields exactly one result beat. The block takes one beat at a time:
// after accepting a beat it stays busy through its check, if any, and until
// the result is loaded into a free output register. A normalized check runs
// four products one after another through the single 32x32 multiplier of
// the gradient unit; a plain check runs one. A finished result sits in the
// output register, and the next beat is taken while it waits there.
// Configuration is written on cfg_we; register 0 is the Q16.16 threshold,
// 1 selects normalized mode, 2 is the check interval (zero acts as one).
// ----------------------------------------------------------------------------
`include "steady_state_gradient_detector_assert.svh"

module steady_state_gradient_detector #(
  parameter int REQUIRED_PASSES = 3,
  parameter int SAMPLE_WIDTH    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sgd_in_if.sink                        in_chan,
  sgd_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [sgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgd_pkg::FIELD_W-1:0]   cfg_data
);
  import sgd_pkg::*;

  localparam int PASS_W = $clog2(REQUIRED_PASSES + 1);

  sgd_state_t state_r, state_nxt;

  // Configuration
  logic [FIELD_W-1:0] thr_r;
  logic               norm_r;
  logic [FIELD_W-1:0] interval_r;
  logic [FIELD_W-1:0] eff_interval;

  // Accepted beat
  logic                    item_type_r;
  logic [FIELD_W-1:0]      item_idx_r;
  logic [SAMPLE_WIDTH-1:0] item_cur_r;
  logic [SAMPLE_WIDTH-1:0] item_t_r;

  // Detector state
  logic [FIELD_W:0]        next_idx_r;
  logic [SAMPLE_WIDTH-1:0] saved_cur_r;
  logic [SAMPLE_WIDTH-1:0] saved_t_r;
  logic                    armed_r;
  logic [FIELD_W-1:0]      armed_idx_r;
  logic [PASS_W-1:0]       passes_r;

  // Results
  sgd_result_t res_r;
  sgd_result_t out_res_r;
  logic        out_valid_r;

  logic              chk;
  logic              rearm;
  logic [FIELD_W:0]  next_from_item;
  logic              unit_start;
  logic [PASS_W-1:0] pass_upd;
  logic              out_free;
  sgd_status_t       unit_status;

  assign eff_interval   = (interval_r == '0) ? FIELD_W'(1) : interval_r;
  assign chk            = armed_r && (item_idx_r > armed_idx_r);
  assign rearm          = {1'b0, item_idx_r} >= next_idx_r;
  assign next_from_item = {1'b0, item_idx_r} + {1'b0, eff_interval};
  assign out_free       = !out_valid_r || out_chan.ready;

  // Saturating pass count after a check
  always_comb begin
    if (!unit_status.passed) begin
      pass_upd = '0;
    end else if (passes_r < REQUIRED_PASSES) begin
      pass_upd = passes_r + 1'b1;
    end else begin
      pass_upd = passes_r;
    end
  end

  sgd_gradient_unit #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (unit_start),
    .norm_mode (norm_r),
    .threshold (thr_r),
    .cur       (item_cur_r),
    .saved_cur (saved_cur_r),
    .t         (item_t_r),
    .saved_t   (saved_t_r),
    .status    (unit_status)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SGD_IDLE: if (in_chan.valid) state_nxt = SGD_EVAL;
      SGD_EVAL: begin
        if (item_type_r == REQ_SAMPLE && chk) begin
          state_nxt = SGD_WAIT;
        end else begin
          state_nxt = SGD_PUSH;
        end
      end
      SGD_WAIT: if (unit_status.done) state_nxt = SGD_PUSH;
      SGD_PUSH: if (out_free) state_nxt = SGD_IDLE;
      default:  state_nxt = SGD_IDLE;
    endcase
  end

  // Handshake outputs and unit kick-off
  always_comb begin
    in_chan.ready = (state_r == SGD_IDLE);
    unit_start    = (state_r == SGD_EVAL) && (item_type_r == REQ_SAMPLE) && chk;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.check_done   = out_res_r.check_done;
  assign out_chan.check_passed = out_res_r.check_passed;
  assign out_chan.pass_count   = out_res_r.pass_count;
  assign out_chan.stop_request = out_res_r.stop_request;

  // Control state, configuration and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SGD_IDLE;
      thr_r       <= '0;
      norm_r      <= 1'b0;
      interval_r  <= FIELD_W'(1);
      next_idx_r  <= (FIELD_W+1)'(1);
      saved_cur_r <= '0;
      saved_t_r   <= '0;
      armed_r     <= 1'b0;
      armed_idx_r <= '0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD:  thr_r      <= cfg_data;
          CFG_NORMALIZED: norm_r     <= cfg_data[0];
          CFG_INTERVAL:   interval_r <= cfg_data;
          default: begin
          end
        endcase
      end

      // Restart clears, or re-arm after the pending check has its operands
      if (state_r == SGD_EVAL) begin
        if (item_type_r == REQ_RESTART) begin
          saved_cur_r <= '0;
          saved_t_r   <= '0;
          next_idx_r  <= next_from_item;
          armed_r     <= 1'b0;
          armed_idx_r <= '0;
          passes_r    <= '0;
        end else if (rearm) begin
          saved_cur_r <= item_cur_r;
          saved_t_r   <= item_t_r;
          next_idx_r  <= next_from_item;
          armed_r     <= 1'b1;
          armed_idx_r <= item_idx_r;
        end else if (chk) begin
          armed_r <= 1'b0;
        end
      end

      // Count the pass streak when the check finishes
      if (state_r == SGD_WAIT && unit_status.done) begin
        passes_r <= pass_upd;
      end

      // Load a new output beat when free, else drop the beat once taken
      if (state_r == SGD_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.valid && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: capture beat, form result, load output register
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_type_r <= in_chan.req_type;
      item_idx_r  <= in_chan.iteration_index;
      item_cur_r  <= in_chan.current_density[SAMPLE_WIDTH-1:0];
      item_t_r    <= in_chan.solved_time[SAMPLE_WIDTH-1:0];
    end
    if (state_r == SGD_EVAL) begin
      res_r.check_done   <= 1'b0;
      res_r.check_passed <= 1'b0;
      res_r.stop_request <= 1'b0;
      if (item_type_r == REQ_RESTART) begin
        res_r.pass_count <= '0;
      end else if (passes_r > PASS_SHOW_MAX) begin
        res_r.pass_count <= PASS_COUNT_W'(PASS_SHOW_MAX);
      end else begin
        res_r.pass_count <= PASS_COUNT_W'(passes_r);
      end
    end
    if (state_r == SGD_WAIT && unit_status.done) begin
      res_r.check_done   <= 1'b1;
      res_r.check_passed <= unit_status.passed;
      res_r.stop_request <= (pass_upd >= REQUIRED_PASSES);
      if (pass_upd > PASS_SHOW_MAX) begin
        res_r.pass_count <= PASS_COUNT_W'(PASS_SHOW_MAX);
      end else begin
        res_r.pass_count <= PASS_COUNT_W'(pass_upd);
      end
    end
    if (state_r == SGD_PUSH && out_free) begin
      out_res_r <= res_r;
    end
  end

  `SSGD_ASSERT(a_busy_after_beat, clk, rst_n, (in_chan.valid && in_chan.ready) |=> !in_chan.ready, "ready right after a beat")
  `SSGD_ASSERT_NEVER(a_done_outside_wait, clk, rst_n, unit_status.done && (state_r != SGD_WAIT), "check finished while not waiting")
  `SSGD_ASSERT(a_push_loads_output, clk, rst_n, (state_r == SGD_PUSH && out_free) |=> out_valid_r, "result not loaded")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the steady-state gradient detector. A driver feeds
// solver samples and restarts from a queue, a monitor predicts every result
// beat with its own copy of the detector state and compares it field by
// field. Both channel sides idle at random; the registers change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sgd_pkg::*;

  localparam int REQUIRED_PASSES = 3;
  localparam int SAMPLE_WIDTH    = 32;
  localparam int WATCHDOG_LIMIT  = 500;
  localparam int SETTLE_CYCLES   = 12;
  localparam int PHASES          = 8;
  localparam int PHASE_BEATS     = 150;

  typedef struct {
    logic                      req;
    logic [FIELD_W-1:0]        idx;
    logic signed [FIELD_W-1:0] cur;
    logic [FIELD_W-1:0]        t;
  } solver_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;

  sgd_in_if  in_bus ();
  sgd_out_if out_bus ();

  steady_state_gradient_detector #(
    .REQUIRED_PASSES (REQUIRED_PASSES),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the detector registers and state
  logic [FIELD_W-1:0]        thr_q16      = '0;
  logic                      norm_sel     = 1'b0;
  logic [FIELD_W-1:0]        interval_reg = 32'd1;
  logic [FIELD_W:0]          next_check   = 33'd1;
  logic signed [FIELD_W-1:0] held_current = '0;
  logic [FIELD_W-1:0]        held_time    = '0;
  logic                      armed        = 1'b0;
  logic [FIELD_W-1:0]        armed_at     = '0;
  int                        pass_run     = 0;

  solver_beat_t sample_queue[$];
  sgd_result_t  expected_verdicts[$];

  logic in_took     = 1'b0;
  logic out_took    = 1'b0;
  int   send_gap    = 0;
  int   drain_stall = 0;
  int   feed_quiet  = 0;
  int   drain_quiet = 0;
  int   idle_cycles = 0;
  int   verdict_errors = 0;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Exact gradient test by cross-multiplication, no rounding
  function automatic logic gradient_below(logic signed [FIELD_W-1:0] cur,
                                          logic [FIELD_W-1:0] t);
    longint       di;
    longint       dt;
    logic [63:0]  di_mag;
    logic [63:0]  dt_mag;
    logic [63:0]  cur_mag;
    logic [127:0] lhs;
    logic [127:0] rhs;
    di = longint'(cur) - longint'(held_current);
    dt = longint'({32'b0, t}) - longint'({32'b0, held_time});
    if (dt == 0) return 1'b0;
    di_mag = (di < 0) ? -di : di;
    dt_mag = (dt < 0) ? -dt : dt;
    lhs = 128'(di_mag) << Q_FRAC;
    rhs = 128'(thr_q16) * 128'(dt_mag);
    if (norm_sel) begin
      if (cur == 0) return 1'b0;
      cur_mag = (cur < 0) ? -longint'(cur) : longint'(cur);
      lhs = lhs * 128'(t);
      rhs = rhs * 128'(cur_mag);
    end
    return lhs < rhs;
  endfunction

  // Advance the mirrored state by one accepted beat, return its verdict
  function automatic sgd_result_t gradient_step(solver_beat_t b);
    sgd_result_t      r;
    logic [FIELD_W:0] span;
    r = '0;
    span = {1'b0, (interval_reg == 0) ? 32'd1 : interval_reg};
    if (b.req == REQ_RESTART) begin
      held_current = '0;
      held_time    = '0;
      next_check   = {1'b0, b.idx} + span;
      armed        = 1'b0;
      armed_at     = '0;
      pass_run     = 0;
    end else begin
      // Evaluate a pending check before re-arming
      if (armed && b.idx > armed_at) begin
        armed = 1'b0;
        r.check_done = 1'b1;
        if (gradient_below(b.cur, b.t)) begin
          r.check_passed = 1'b1;
          if (pass_run < REQUIRED_PASSES) pass_run++;
        end else begin
          pass_run = 0;
        end
        r.stop_request = (pass_run >= REQUIRED_PASSES);
      end
      if ({1'b0, b.idx} >= next_check) begin
        held_current = b.cur;
        held_time    = b.t;
        next_check   = {1'b0, b.idx} + span;
        armed        = 1'b1;
        armed_at     = b.idx;
      end
    end
    r.pass_count = PASS_COUNT_W'((pass_run > PASS_SHOW_MAX) ? PASS_SHOW_MAX : pass_run);
    return r;
  endfunction

  // Idle length for one beat, with occasional stretches of no idling
  function automatic int pause_len(input int quiet, output int quiet_next);
    quiet_next = quiet;
    if (quiet > 0) begin
      quiet_next = quiet - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_next = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  task automatic queue_beat(input logic req, input logic [FIELD_W-1:0] idx,
                            input logic signed [FIELD_W-1:0] cur,
                            input logic [FIELD_W-1:0] t);
    solver_beat_t b;
    b.req = req;
    b.idx = idx;
    b.cur = cur;
    b.t   = t;
    sample_queue.push_back(b);
  endtask

  // One solver run: a restart, then mostly advancing samples with slow drift
  task automatic queue_run(input int n);
    logic [FIELD_W-1:0]        idx;
    logic [FIELD_W-1:0]        t;
    logic signed [FIELD_W-1:0] cur;
    int                        step;
    int                        dt_max;
    int                        roll;
    idx    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1000);
    cur    = $urandom;
    t      = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
    step   = $urandom_range(0, 1 << $urandom_range(0, 16));
    dt_max = $urandom_range(1, 1000);
    queue_beat(REQ_RESTART, idx, $urandom, $urandom);
    for (int k = 1; k < n; k++) begin
      roll = $urandom_range(0, 19);
      if (roll < 2) begin
        // noise beat, any type and any content
        queue_beat(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      end else begin
        if (roll == 2) idx = idx - $urandom_range(0, 2);
        else idx = idx + $urandom_range(1, 3);
        if (roll == 3) t = t - $urandom_range(0, dt_max);
        else t = t + $urandom_range(1, dt_max);
        cur = cur + (int'($urandom_range(0, 2 * step)) - step);
        queue_beat(REQ_SAMPLE, idx, cur, t);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_THRESHOLD:  thr_q16 = data;
      CFG_NORMALIZED: norm_sel = data[0];
      CFG_INTERVAL:   interval_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Hold until every beat is sent and every verdict is back, then pause
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_bus.valid || expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input driver: hold each beat until taken, then wait its gap
  always @(negedge clk) begin : feed
    solver_beat_t b;
    int           gap;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_took) begin
      if (send_gap > 0) begin
        send_gap     <= send_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        b = sample_queue.pop_front();
        in_bus.req_type        <= b.req;
        in_bus.iteration_index <= b.idx;
        in_bus.current_density <= b.cur;
        in_bus.solved_time     <= b.t;
        in_bus.valid           <= 1'b1;
        gap = pause_len(feed_quiet, feed_quiet);
        send_gap <= gap;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall a random number of cycles after each beat
  always @(negedge clk) begin : drain
    int stall;
    if (out_took) begin
      stall = pause_len(drain_quiet, drain_quiet);
      drain_stall   <= stall;
      out_bus.ready <= (stall == 0);
    end else if (drain_stall > 0) begin
      drain_stall   <= drain_stall - 1;
      out_bus.ready <= (drain_stall == 1);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin : watch
    solver_beat_t b;
    sgd_result_t  got;
    sgd_result_t  want;
    logic         fin;
    logic         fout;
    fin  = rst_n && in_bus.valid && in_bus.ready;
    fout = rst_n && out_bus.valid && out_bus.ready;
    in_took  <= fin;
    out_took <= fout;
    idle_cycles <= (fin || fout || cfg_we || !rst_n) ? 0 : idle_cycles + 1;
    if (fin) begin
      b.req = in_bus.req_type;
      b.idx = in_bus.iteration_index;
      b.cur = in_bus.current_density;
      b.t   = in_bus.solved_time;
      expected_verdicts.push_back(gradient_step(b));
    end
    if (fout) begin
      got.check_done   = out_bus.check_done;
      got.check_passed = out_bus.check_passed;
      got.pass_count   = out_bus.pass_count;
      got.stop_request = out_bus.stop_request;
      if (expected_verdicts.size() == 0) begin
        if (verdict_errors < 10)
          $display("unexpected result beat: done=%0b passed=%0b count=%0d stop=%0b",
                   got.check_done, got.check_passed, got.pass_count, got.stop_request);
        verdict_errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          if (verdict_errors < 10)
            $display("verdict mismatch: exp done=%0b passed=%0b count=%0d stop=%0b, %s",
                     want.check_done, want.check_passed, want.pass_count,
                     want.stop_request,
                     $sformatf("got done=%0b passed=%0b count=%0d stop=%0b",
                               got.check_done, got.check_passed, got.pass_count,
                               got.stop_request));
          verdict_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int left;
    int len;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_THRESHOLD;
    cfg_data               = '0;
    in_bus.valid           = 1'b0;
    in_bus.req_type        = REQ_SAMPLE;
    in_bus.iteration_index = '0;
    in_bus.current_density = '0;
    in_bus.solved_time     = '0;
    out_bus.ready          = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero threshold, plain test, interval one
    queue_beat(REQ_SAMPLE, 32'd0, 32'sd0, 32'd0);
    queue_beat(REQ_SAMPLE, 32'd1, 32'sd100, 32'd10);
    queue_beat(REQ_SAMPLE, 32'd1, 32'sd100, 32'd20);
    queue_beat(REQ_SAMPLE, 32'd2, 32'sd100, 32'd30);
    wait_idle();

    // Widest threshold, interval zero acts as one
    write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(CFG_NORMALIZED, 32'd0);
    write_reg(CFG_INTERVAL, 32'd0);
    cfg_we <= 1'b0;
    queue_beat(REQ_RESTART, 32'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    queue_beat(REQ_SAMPLE, 32'd1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    queue_beat(REQ_SAMPLE, 32'd2, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    queue_beat(REQ_SAMPLE, 32'd3, 32'sh8000_0000, 32'd0);
    queue_beat(REQ_SAMPLE, 32'd4, 32'sh8000_0000, 32'd1);
    queue_beat(REQ_SAMPLE, 32'd5, 32'sh8000_0001, 32'd2);
    queue_beat(REQ_SAMPLE, 32'd6, 32'sh8000_0001, 32'd3);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFFF, -32'sd5, 32'd7);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFFF, -32'sd5, 32'd9);
    wait_idle();

    // Normalized test near the top of the index range
    write_reg(CFG_NORMALIZED, 32'd1);
    write_reg(CFG_INTERVAL, 32'd3);
    cfg_we <= 1'b0;
    queue_beat(REQ_RESTART, 32'hFFFF_FFF0, 32'sd0, 32'd0);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFF3, 32'sd1000, 32'd100);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFF4, 32'sd0, 32'd200);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFF6, 32'sd1000, 32'd300);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFF7, 32'sd1001, 32'd400);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFFA, -32'sd7, 32'd500);
    queue_beat(REQ_RESTART, 32'd5, 32'sd0, 32'd0);
    wait_idle();

    // Widest interval: next check index past 32 bits
    write_reg(CFG_THRESHOLD, 32'h0001_0000);
    write_reg(CFG_NORMALIZED, 32'd0);
    write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    queue_beat(REQ_RESTART, 32'hFFFF_FFFF, 32'sd0, 32'd0);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFFF, -32'sd1, 32'd5);
    queue_beat(REQ_RESTART, 32'd0, 32'sd0, 32'd0);
    queue_beat(REQ_SAMPLE, 32'hFFFF_FFFF, -32'sd1, 32'd5);
    queue_beat(REQ_SAMPLE, 32'd0, -32'sd1, 32'd6);

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_THRESHOLD, (p == 3) ? 32'd0 :
                               (p == 6) ? 32'hFFFF_FFFF :
                               $urandom_range(32'h400, 32'h10_0000));
      write_reg(CFG_NORMALIZED, p % 2);
      write_reg(CFG_INTERVAL, (p == 5) ? 32'd0 : $urandom_range(1, 4));
      cfg_we <= 1'b0;
      left = PHASE_BEATS;
      while (left > 0) begin
        len = $urandom_range(5, 40);
        if (len > left) len = left;
        queue_run(len);
        left -= len;
      end
    end

    // Drain, then allow for any stray result beat
    wait_idle();
    repeat (20) @(negedge clk);
    if (verdict_errors == 0 && expected_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
